### src/rvid_pkg.sv
package rvid_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CLS_W  = 4;
  localparam int unsigned KIND_W = 6;
  localparam int unsigned REG_W  = 5;

  localparam logic [6:0] OP_R      = 7'b0110011;
  localparam logic [6:0] OP_ARITH  = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_B   = 3'd0;
  localparam logic [2:0] F3_H   = 3'd1;
  localparam logic [2:0] F3_W   = 3'd2;
  localparam logic [2:0] F3_BU  = 3'd4;
  localparam logic [2:0] F3_HU  = 3'd5;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  typedef enum logic [CLS_W-1:0] {
    CLS_R      = 4'd0,
    CLS_ARITH  = 4'd1,
    CLS_LOAD   = 4'd2,
    CLS_JALR   = 4'd3,
    CLS_STORE  = 4'd4,
    CLS_UPPER  = 4'd5,
    CLS_JAL    = 4'd6,
    CLS_BRANCH = 4'd7,
    CLS_EXIT   = 4'd8
  } cls_t;

  typedef enum logic [KIND_W-1:0] {
    K_ADD = 6'd0, K_SUB = 6'd1, K_SLL = 6'd2, K_SLT = 6'd3, K_SLTU = 6'd4,
    K_XOR = 6'd5, K_SRL = 6'd6, K_SRA = 6'd7, K_OR = 6'd8, K_AND = 6'd9,
    K_ADDI = 6'd10, K_SLLI = 6'd11, K_SLTI = 6'd12, K_SLTIU = 6'd13,
    K_XORI = 6'd14, K_SRLI = 6'd15, K_SRAI = 6'd16, K_ORI = 6'd17,
    K_ANDI = 6'd18,
    K_LB = 6'd19, K_LH = 6'd20, K_LW = 6'd21, K_LBU = 6'd22, K_LHU = 6'd23,
    K_JALR = 6'd24,
    K_SB = 6'd25, K_SH = 6'd26, K_SW = 6'd27,
    K_LUI = 6'd28, K_AUIPC = 6'd29,
    K_JAL = 6'd30,
    K_BEQ = 6'd31, K_BNE = 6'd32, K_BLT = 6'd33, K_BGE = 6'd34,
    K_BLTU = 6'd35, K_BGEU = 6'd36
  } kind_t;

  typedef struct packed {
    cls_t              cls;
    kind_t             kind;
    logic              illegal;
    logic [REG_W-1:0]  rd;
    logic [REG_W-1:0]  rs1;
    logic [REG_W-1:0]  rs2;
    logic [WORD_W-1:0] imm;
  } dec_t;

endpackage

### src/rv32i_instruction_decoder.sv
// rv32i instruction decoder
//
// input channel: in_valid / in_ready carry one 32-bit instruction word per
// beat. result channel: out_valid / out_ready carry the format class,
// instruction kind, illegal flag, rd / rs1 / rs2 and the reassembled
// immediate (zero-extended, upper format keeps bits 31:12).
//
// the word is captured in an input register, decoded by a short opcode /
// func3 / func7 selection and caught in the result register, which drives
// out_valid. throughput is one beat per cycle while the receiver takes
// results, set by the combinational decode between the two registers.
//
// when the receiver stalls the result register holds its beat and the
// input register can still take one more word, so the input side only
// backs up once both registers are full.
// reset clears both valid flags; the data registers are not reset.
module rv32i_instruction_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rvid_pkg::WORD_W-1:0]      in_instruction_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rvid_pkg::CLS_W-1:0]       out_format_class,
  output logic [rvid_pkg::KIND_W-1:0]      out_instruction_kind,
  output logic                             out_illegal,
  output logic [rvid_pkg::REG_W-1:0]       out_dest_reg,
  output logic [rvid_pkg::REG_W-1:0]       out_source_reg_one,
  output logic [rvid_pkg::REG_W-1:0]       out_source_reg_two,
  output logic [rvid_pkg::WORD_W-1:0]      out_immediate
);

  logic                        in_valid_r;
  logic [rvid_pkg::WORD_W-1:0] word_r;
  logic                        out_valid_r;
  rvid_pkg::dec_t              dec_r;
  rvid_pkg::dec_t              dec_nxt;
  logic                        adv;

  logic [6:0] op;
  logic [2:0] f3;
  logic [6:0] f7;
  logic       bad;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || adv;

  assign op = word_r[6:0];
  assign f3 = word_r[14:12];
  assign f7 = word_r[31:25];

  always_comb begin
    dec_nxt = '0;
    dec_nxt.cls  = rvid_pkg::CLS_EXIT;
    dec_nxt.kind = rvid_pkg::K_ADD;
    bad = 1'b0;
    unique case (op)
      rvid_pkg::OP_R: begin
        dec_nxt.cls = rvid_pkg::CLS_R;
        dec_nxt.rd  = word_r[11:7];
        dec_nxt.rs1 = word_r[19:15];
        dec_nxt.rs2 = word_r[24:20];
        unique case (f3)
          rvid_pkg::F3_ADD: begin
            if (f7 == rvid_pkg::F7_BASE) dec_nxt.kind = rvid_pkg::K_ADD;
            else if (f7 == rvid_pkg::F7_ALT) dec_nxt.kind = rvid_pkg::K_SUB;
            else bad = 1'b1;
          end
          rvid_pkg::F3_SLL:  dec_nxt.kind = rvid_pkg::K_SLL;
          rvid_pkg::F3_SLT:  dec_nxt.kind = rvid_pkg::K_SLT;
          rvid_pkg::F3_SLTU: dec_nxt.kind = rvid_pkg::K_SLTU;
          rvid_pkg::F3_XOR:  dec_nxt.kind = rvid_pkg::K_XOR;
          rvid_pkg::F3_SR: begin
            if (f7 == rvid_pkg::F7_BASE) dec_nxt.kind = rvid_pkg::K_SRL;
            else if (f7 == rvid_pkg::F7_ALT) dec_nxt.kind = rvid_pkg::K_SRA;
            else bad = 1'b1;
          end
          rvid_pkg::F3_OR:   dec_nxt.kind = rvid_pkg::K_OR;
          default:           dec_nxt.kind = rvid_pkg::K_AND;
        endcase
      end
      rvid_pkg::OP_ARITH: begin
        dec_nxt.cls = rvid_pkg::CLS_ARITH;
        dec_nxt.rd  = word_r[11:7];
        dec_nxt.rs1 = word_r[19:15];
        dec_nxt.imm = {20'b0, word_r[31:20]};
        unique case (f3)
          rvid_pkg::F3_ADD:  dec_nxt.kind = rvid_pkg::K_ADDI;
          rvid_pkg::F3_SLL:  dec_nxt.kind = rvid_pkg::K_SLLI;
          rvid_pkg::F3_SLT:  dec_nxt.kind = rvid_pkg::K_SLTI;
          rvid_pkg::F3_SLTU: dec_nxt.kind = rvid_pkg::K_SLTIU;
          rvid_pkg::F3_XOR:  dec_nxt.kind = rvid_pkg::K_XORI;
          rvid_pkg::F3_SR: begin
            if (f7 == rvid_pkg::F7_BASE) dec_nxt.kind = rvid_pkg::K_SRLI;
            else if (f7 == rvid_pkg::F7_ALT) dec_nxt.kind = rvid_pkg::K_SRAI;
            else bad = 1'b1;
          end
          rvid_pkg::F3_OR:   dec_nxt.kind = rvid_pkg::K_ORI;
          default:           dec_nxt.kind = rvid_pkg::K_ANDI;
        endcase
      end
      rvid_pkg::OP_LOAD: begin
        dec_nxt.cls = rvid_pkg::CLS_LOAD;
        dec_nxt.rd  = word_r[11:7];
        dec_nxt.rs1 = word_r[19:15];
        dec_nxt.imm = {20'b0, word_r[31:20]};
        unique case (f3)
          rvid_pkg::F3_B:  dec_nxt.kind = rvid_pkg::K_LB;
          rvid_pkg::F3_H:  dec_nxt.kind = rvid_pkg::K_LH;
          rvid_pkg::F3_W:  dec_nxt.kind = rvid_pkg::K_LW;
          rvid_pkg::F3_BU: dec_nxt.kind = rvid_pkg::K_LBU;
          rvid_pkg::F3_HU: dec_nxt.kind = rvid_pkg::K_LHU;
          default:         bad = 1'b1;
        endcase
      end
      rvid_pkg::OP_JALR: begin
        // func3 is not checked here
        dec_nxt.cls  = rvid_pkg::CLS_JALR;
        dec_nxt.rd   = word_r[11:7];
        dec_nxt.rs1  = word_r[19:15];
        dec_nxt.imm  = {20'b0, word_r[31:20]};
        dec_nxt.kind = rvid_pkg::K_JALR;
      end
      rvid_pkg::OP_STORE: begin
        dec_nxt.cls = rvid_pkg::CLS_STORE;
        dec_nxt.rs1 = word_r[19:15];
        dec_nxt.rs2 = word_r[24:20];
        dec_nxt.imm = {20'b0, word_r[31:25], word_r[11:7]};
        unique case (f3)
          rvid_pkg::F3_B: dec_nxt.kind = rvid_pkg::K_SB;
          rvid_pkg::F3_H: dec_nxt.kind = rvid_pkg::K_SH;
          rvid_pkg::F3_W: dec_nxt.kind = rvid_pkg::K_SW;
          default:        bad = 1'b1;
        endcase
      end
      rvid_pkg::OP_LUI, rvid_pkg::OP_AUIPC: begin
        dec_nxt.cls  = rvid_pkg::CLS_UPPER;
        dec_nxt.rd   = word_r[11:7];
        dec_nxt.imm  = {word_r[31:12], 12'b0};
        dec_nxt.kind = (op == rvid_pkg::OP_LUI) ? rvid_pkg::K_LUI : rvid_pkg::K_AUIPC;
      end
      rvid_pkg::OP_JAL: begin
        dec_nxt.cls  = rvid_pkg::CLS_JAL;
        dec_nxt.rd   = word_r[11:7];
        dec_nxt.imm  = {11'b0, word_r[31], word_r[19:12], word_r[20],
                        word_r[30:21], 1'b0};
        dec_nxt.kind = rvid_pkg::K_JAL;
      end
      rvid_pkg::OP_BRANCH: begin
        dec_nxt.cls = rvid_pkg::CLS_BRANCH;
        dec_nxt.rs1 = word_r[19:15];
        dec_nxt.rs2 = word_r[24:20];
        dec_nxt.imm = {19'b0, word_r[31], word_r[7], word_r[30:25],
                       word_r[11:8], 1'b0};
        unique case (f3)
          rvid_pkg::F3_BEQ:  dec_nxt.kind = rvid_pkg::K_BEQ;
          rvid_pkg::F3_BNE:  dec_nxt.kind = rvid_pkg::K_BNE;
          rvid_pkg::F3_BLT:  dec_nxt.kind = rvid_pkg::K_BLT;
          rvid_pkg::F3_BGE:  dec_nxt.kind = rvid_pkg::K_BGE;
          rvid_pkg::F3_BLTU: dec_nxt.kind = rvid_pkg::K_BLTU;
          rvid_pkg::F3_BGEU: dec_nxt.kind = rvid_pkg::K_BGEU;
          default:           bad = 1'b1;
        endcase
      end
      default: begin
        dec_nxt.cls = rvid_pkg::CLS_EXIT;
      end
    endcase
    // func fields flagged as bad report kind zero
    if (bad) begin
      dec_nxt.kind = rvid_pkg::K_ADD;
    end
    dec_nxt.illegal = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_instruction_word;
    end
    if (adv && in_valid_r) begin
      dec_r <= dec_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_format_class     = dec_r.cls;
  assign out_instruction_kind = dec_r.kind;
  assign out_illegal          = dec_r.illegal;
  assign out_dest_reg         = dec_r.rd;
  assign out_source_reg_one   = dec_r.rs1;
  assign out_source_reg_two   = dec_r.rs2;
  assign out_immediate        = dec_r.imm;

  // a held input beat moves to the result register once it frees up
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && adv |=> out_valid_r)
    else $error("decoded beat not moved to result register");

  // a stalled result with a full input register blocks the input side
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted with both registers full");

  a_illegal_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |-> out_instruction_kind == '0)
    else $error("illegal beat with nonzero kind");

  a_exit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_format_class == rvid_pkg::CLS_EXIT |->
      !out_illegal && out_dest_reg == '0 && out_source_reg_one == '0 &&
      out_source_reg_two == '0 && out_immediate == '0)
    else $error("unknown opcode beat carries fields");

  a_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_format_class == rvid_pkg::CLS_STORE ||
                  out_format_class == rvid_pkg::CLS_BRANCH) |->
      out_dest_reg == '0)
    else $error("store or branch with destination register");

endmodule
